// ----- rtl/core/rtctz_pkg.sv -----
`default_nettype none

package rtctz_pkg;

    // Month carry steps after the borrow stage; a day of up to 260 settles
    // within eight months from any starting month.
    localparam int CARRY_STAGES = 9;

    // Status B bit that selects binary over BCD
    localparam int STATUS_BIN_BIT = 2;

    localparam logic [11:0] YEAR_BASE  = 12'd2000;
    localparam logic [7:0]  MONTH_FIRST = 8'd1;
    localparam logic [7:0]  MONTH_LAST  = 8'd12;

    // Calendar item handed between the carry stages
    typedef struct packed {
        logic [5:0]  seconds;
        logic [5:0]  minutes;
        logic [4:0]  hours;
        logic [8:0]  day;
        logic [7:0]  month;
        logic [11:0] year;
    } cal_t;

    // Two BCD digits to binary; digits above nine take part as they are
    function automatic logic [7:0] bcd_byte(input logic [7:0] b);
        logic [7:0] hi;
        hi = {4'd0, b[7:4]};
        bcd_byte = {4'd0, b[3:0]} + {hi[4:0], 3'd0} + {hi[6:0], 1'b0};
    endfunction

    // Leap year; the year in this block stays within 1999..2260, so the only
    // centurial non-leap years that can appear are 2100 and 2200
    function automatic logic leap_year(input logic [11:0] y);
        leap_year = (y[1:0] == 2'd0) && (y != 12'd2100) && (y != 12'd2200);
    endfunction

    // Days in a month; a month outside 1..12 counts as 31 days
    function automatic logic [4:0] month_days(input logic [7:0] m, input logic [11:0] y);
        case (m) inside
            8'd2:                      month_days = leap_year(y) ? 5'd29 : 5'd28;
            8'd4, 8'd6, 8'd9, 8'd11:   month_days = 5'd30;
            default:                   month_days = 5'd31;
        endcase
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/rtctz_carry_stage.sv -----
`default_nettype none

module rtctz_carry_stage
    import rtctz_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire cal_t in_data,
    output logic      out_valid,
    input  wire logic out_ready,
    output cal_t      out_data
);

    logic       valid_reg;
    cal_t       data_reg;
    cal_t       data_next;
    logic [4:0] mdays;
    logic [8:0] month_inc;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // Carry one month when the day overruns the current month
    always_comb begin
        data_next = in_data;
        mdays     = month_days(in_data.month, in_data.year);
        month_inc = {1'b0, in_data.month} + 9'd1;
        if (in_data.day > {4'd0, mdays}) begin
            data_next.day = in_data.day - {4'd0, mdays};
            if (month_inc > {1'b0, MONTH_LAST}) begin
                data_next.month = MONTH_FIRST;
                data_next.year  = in_data.year + 12'd1;
            end else begin
                data_next.month = month_inc[7:0];
            end
        end
    end

    // Hold the stage while downstream stalls
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/rtc_bcd_decode_timezone_adjust_top.sv -----
`default_nettype none

// Channel  Direction  Width  Contents
// s_       in         56     one RTC snapshot request, seven raw register bytes
// m_       out        40     decoded, zone-adjusted date and time
// cfg_     in         5      signed hour offset (reset +5)
//
// One request accepted every cycle unless a full stage is stalled by m_tready;
// each request passes through the input register, decode/hour stage, day borrow
// stage and nine month carry stages, the last of which is the output register.
// aresetn is synchronous; it empties the pipeline and sets the offset to +5.
// Each stage holds only while the stage after it is full and stalled, so
// requests keep entering while bubbles remain ahead.
module rtc_bcd_decode_timezone_adjust_top
    import rtctz_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // raw_seconds[7:0], raw_minutes[15:8], raw_hours[23:16], raw_day[31:24],
    // raw_month[39:32], raw_year[47:40], status_b[55:48]
    input  wire logic [55:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // out_seconds[5:0], out_minutes[11:6], out_hours[16:12], out_day[21:17],
    // out_month[25:22], out_year[37:26], zero [39:38]
    output logic [39:0]      m_tdata,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [4:0]  cfg_data
);

    logic signed [4:0] offset_reg;

    // Input register
    logic        v0_reg;
    logic [55:0] raw_reg;
    logic        rdy0;

    // Decode and hour stage
    logic              v1_reg;
    logic [5:0]        sec1_reg, min1_reg;
    logic [4:0]        hour1_reg;
    logic signed [9:0] day1_reg;
    logic [7:0]        month1_reg;
    logic [11:0]       year1_reg;
    logic              rdy1;

    logic [7:0]        sec_dec, min_dec, day_dec, month_dec, year_dec;
    logic [6:0]        hour_dec;
    logic signed [8:0] hour_sum;
    logic signed [8:0] hour_wrap;
    logic signed [3:0] day_carry;
    logic signed [9:0] day_sum;

    // Borrow stage
    logic       v2_reg;
    cal_t       cal2_reg;
    cal_t       cal2_next;
    logic       rdy2;
    logic [7:0] month_prev;
    logic [11:0] year_prev;
    logic [9:0] day_borrow;

    // Carry chain
    logic [CARRY_STAGES:0] chain_valid;
    logic [CARRY_STAGES:0] chain_ready;
    cal_t                  chain_data [CARRY_STAGES+1];

    assign cfg_ready = 1'b1;

    // Take the offset on every write request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg <= 5'sd5;
        end else if (cfg_valid) begin
            offset_reg <= cfg_data;
        end
    end

    // Ready chain, back from the carry stages
    assign rdy2     = !v2_reg || chain_ready[0];
    assign rdy1     = !v1_reg || rdy2;
    assign rdy0     = !v0_reg || rdy1;
    assign s_tready = rdy0;

    // Capture the raw snapshot
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (rdy0) begin
            v0_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy0 && s_tvalid) begin
            raw_reg <= s_tdata;
        end
    end

    // Decode the bytes (BCD unless status B selects binary), add the offset and wrap the hour
    always_comb begin
        if (!raw_reg[48 + STATUS_BIN_BIT]) begin
            sec_dec   = bcd_byte(raw_reg[7:0]);
            min_dec   = bcd_byte(raw_reg[15:8]);
            hour_dec  = 7'(bcd_byte({1'b0, raw_reg[22:16]}));
            day_dec   = bcd_byte(raw_reg[31:24]);
            month_dec = bcd_byte(raw_reg[39:32]);
            year_dec  = bcd_byte(raw_reg[47:40]);
        end else begin
            sec_dec   = raw_reg[7:0];
            min_dec   = raw_reg[15:8];
            hour_dec  = raw_reg[22:16];
            day_dec   = raw_reg[31:24];
            month_dec = raw_reg[39:32];
            year_dec  = raw_reg[47:40];
        end

        hour_sum = $signed({2'b00, hour_dec}) + $signed({{4{offset_reg[4]}}, offset_reg});

        if (hour_sum < 9'sd0) begin
            hour_wrap = hour_sum + 9'sd24;
            day_carry = -4'sd1;
        end else if (hour_sum >= 9'sd120) begin
            hour_wrap = hour_sum - 9'sd120;
            day_carry = 4'sd5;
        end else if (hour_sum >= 9'sd96) begin
            hour_wrap = hour_sum - 9'sd96;
            day_carry = 4'sd4;
        end else if (hour_sum >= 9'sd72) begin
            hour_wrap = hour_sum - 9'sd72;
            day_carry = 4'sd3;
        end else if (hour_sum >= 9'sd48) begin
            hour_wrap = hour_sum - 9'sd48;
            day_carry = 4'sd2;
        end else if (hour_sum >= 9'sd24) begin
            hour_wrap = hour_sum - 9'sd24;
            day_carry = 4'sd1;
        end else begin
            hour_wrap = hour_sum;
            day_carry = 4'sd0;
        end

        day_sum = $signed({2'b00, day_dec}) + $signed({{6{day_carry[3]}}, day_carry});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (rdy1) begin
            v1_reg <= v0_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && v0_reg) begin
            sec1_reg   <= sec_dec[5:0];
            min1_reg   <= min_dec[5:0];
            hour1_reg  <= hour_wrap[4:0];
            day1_reg   <= day_sum;
            month1_reg <= month_dec;
            year1_reg  <= YEAR_BASE + {4'd0, year_dec};
        end
    end

    // Borrow one month when the day drops below one
    always_comb begin
        cal2_next.seconds = sec1_reg;
        cal2_next.minutes = min1_reg;
        cal2_next.hours   = hour1_reg;
        if (month1_reg <= MONTH_FIRST) begin
            month_prev = MONTH_LAST;
            year_prev  = year1_reg - 12'd1;
        end else begin
            month_prev = month1_reg - 8'd1;
            year_prev  = year1_reg;
        end
        day_borrow = day1_reg + $signed({5'd0, month_days(month_prev, year_prev)});
        if (day1_reg < 10'sd1) begin
            cal2_next.day   = day_borrow[8:0];
            cal2_next.month = month_prev;
            cal2_next.year  = year_prev;
        end else begin
            cal2_next.day   = day1_reg[8:0];
            cal2_next.month = month1_reg;
            cal2_next.year  = year1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (rdy2) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy2 && v1_reg) begin
            cal2_reg <= cal2_next;
        end
    end

    // Month carry stages
    assign chain_valid[0] = v2_reg;
    assign chain_data[0]  = cal2_reg;
    assign chain_ready[CARRY_STAGES] = m_tready;

    for (genvar i = 0; i < CARRY_STAGES; i++) begin : g_carry
        rtctz_carry_stage u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (chain_valid[i]),
            .in_ready  (chain_ready[i]),
            .in_data   (chain_data[i]),
            .out_valid (chain_valid[i+1]),
            .out_ready (chain_ready[i+1]),
            .out_data  (chain_data[i+1])
        );
    end

    // Pack the result from the last stage
    assign m_tvalid = chain_valid[CARRY_STAGES];
    assign m_tdata  = {2'b00,
                       chain_data[CARRY_STAGES].year,
                       chain_data[CARRY_STAGES].month[3:0],
                       chain_data[CARRY_STAGES].day[4:0],
                       chain_data[CARRY_STAGES].hours,
                       chain_data[CARRY_STAGES].minutes,
                       chain_data[CARRY_STAGES].seconds};

endmodule

`default_nettype wire
